[hdl/sha256_pkg.sv]
// SHA-256 shared types, constants and round functions.
package sha256_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } item_t;

  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 4;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  function automatic logic [31:0] iv_word(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

[hdl/sha256_queue.sv]
// Small FIFO between the item front end and the hashing engine.
module sha256_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  sha256_pkg::item_t    wr_item,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output sha256_pkg::item_t    rd_item
);
  localparam int unsigned AW = $clog2(sha256_pkg::QUEUE_DEPTH);

  sha256_pkg::item_t mem_r [sha256_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          wr_en, rd_en;

  assign wr_ready = (cnt_r != (AW+1)'(sha256_pkg::QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(sha256_pkg::QUEUE_DEPTH)) else $error("queue overflow");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count slip");
  a_empty_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wp_r == rp_r)) else $error("pointer slip");
endmodule

[hdl/sha256_engine.sv]
// Hashing engine: block buffer, padding sequencer, 64-round compressor, digest out.
module sha256_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  output logic               item_ready,
  input  sha256_pkg::item_t  item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_digest_word,
  output logic [2:0]         out_word_index,
  output logic               out_last_word
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;  // write pad bytes
  localparam logic [2:0] S_LOAD = 3'd2;  // read 16 words into schedule
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  st_r, st_nxt;
  logic [5:0]  pend_r;
  logic [60:0] msg_r;
  logic        fin_r;      // current compression is part of finish
  logic        last_blk_r; // finish: this block holds the length
  logic [63:0] bits_r;

  logic [31:0] mem_r [16]; // block as words, byte-writable
  logic [31:0] w_r [16];
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [5:0]  t_r;
  logic [4:0]  lc_r;       // load counter
  logic [2:0]  oi_r;
  logic        ov_r;

  // pad byte value for position pend_r while in S_PAD
  logic [7:0]  pad_byte;
  logic [2:0]  li;
  assign li = 3'(pend_r - 6'd56);
  always_comb begin
    if (last_blk_r && pend_r >= 6'd56) pad_byte = bits_r[8'(7 - li) * 8 +: 8];
    else                               pad_byte = 8'h00;
  end

  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_data;
  logic        absorb_go, finish_go;

  assign item_ready = (st_r == S_IDLE);
  assign absorb_go  = item_valid && item_ready && item.action == sha256_pkg::ACT_ABSORB;
  assign finish_go  = item_valid && item_ready && item.action == sha256_pkg::ACT_FINISH;

  always_comb begin
    wr_en = 1'b0; wr_addr = pend_r; wr_data = item.data_byte;
    if (absorb_go) wr_en = 1'b1;
    else if (finish_go) begin wr_en = 1'b1; wr_data = 8'h80; end
    else if (st_r == S_PAD) begin wr_en = 1'b1; wr_data = pad_byte; end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr[5:2]][8'(3 - wr_addr[1:0]) * 8 +: 8] <= wr_data;
    end
  end

  // round logic
  logic [31:0] s0, s1, nw, t1, t2, e, a, ch, mj;
  assign s0 = sha256_pkg::rotr(w_r[1], 7) ^ sha256_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1 = sha256_pkg::rotr(w_r[14], 17) ^ sha256_pkg::rotr(w_r[14], 19)
            ^ (w_r[14] >> 10);
  assign nw = w_r[0] + s0 + w_r[9] + s1;
  assign a  = v_r[0];
  assign e  = v_r[4];
  assign ch = (e & v_r[5]) ^ (~e & v_r[6]);
  assign mj = (a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1 = v_r[7] + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11)
            ^ sha256_pkg::rotr(e, 25)) + ch + sha256_pkg::round_k(t_r) + w_r[0];
  assign t2 = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22))
            + mj;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (absorb_go && pend_r == 6'd63) st_nxt = S_LOAD;
        else if (finish_go) st_nxt = (pend_r == 6'd63) ? S_LOAD : S_PAD;
      end
      S_PAD:  if (pend_r == 6'd63 || (!last_blk_r && pend_r == 6'd63)) st_nxt = S_LOAD;
      S_LOAD: if (lc_r == 5'd15) st_nxt = S_RND;
      S_RND:  if (t_r == 6'd63) st_nxt = S_ADD;
      S_ADD:  begin
        if (!fin_r) st_nxt = S_IDLE;
        else if (!last_blk_r) st_nxt = S_PAD;
        else st_nxt = S_OUT;
      end
      S_OUT:  if (out_ready && oi_r == 3'd7) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; pend_r <= '0; msg_r <= '0; fin_r <= 1'b0;
      last_blk_r <= 1'b0; t_r <= '0; lc_r <= '0; oi_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::iv_word(3'(i));
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        S_IDLE: begin
          lc_r <= '0;
          if (absorb_go) begin
            pend_r <= pend_r + 1'b1;
            msg_r  <= msg_r + 1'b1;
          end else if (finish_go) begin
            fin_r      <= 1'b1;
            bits_r     <= {msg_r, 3'b000};
            last_blk_r <= (pend_r < 6'd56);
            pend_r     <= pend_r + 1'b1;
          end
        end
        S_PAD: pend_r <= pend_r + 1'b1;
        S_LOAD: begin
          w_r[lc_r[3:0]] <= mem_r[lc_r[3:0]];
          lc_r <= lc_r + 1'b1;
          t_r  <= '0;
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        end
        S_RND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= nw;
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          t_r <= t_r + 1'b1;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          pend_r <= '0;
          lc_r   <= '0;
          oi_r   <= '0;
          if (fin_r && !last_blk_r) last_blk_r <= 1'b1;
        end
        S_OUT: begin
          if (out_ready) begin
            oi_r <= oi_r + 1'b1;
            if (oi_r == 3'd7) begin
              fin_r <= 1'b0; last_blk_r <= 1'b0; msg_r <= '0;
              for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::iv_word(3'(i));
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign ov_r            = (st_r == S_OUT);
  assign out_valid       = ov_r;
  assign out_digest_word = h_r[oi_r];
  assign out_word_index  = oi_r;
  assign out_last_word   = (oi_r == 3'd7);

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !item_ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(oi_r)) else $error("digest dropped");
  a_rnd_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RND && t_r == 6'd63) |=> st_r == S_ADD) else $error("round count slip");
  a_out_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> fin_r && last_blk_r) else $error("digest without finish");
endmodule

[hdl/sha256_message_hasher.sv]
// SHA-256 message hasher top level: input queue plus hashing engine.
// Items (one message byte, or finish) enter through a 4-deep queue, so the
// input side keeps accepting while the engine compresses, until the queue
// fills. The engine takes one byte per cycle while idle; every 64th byte
// starts a compression: a 16-word schedule load, 64 rounds (one round per
// cycle through a single round unit) and the add. A finish pads the block
// one byte per cycle, runs one or two compressions, then presents the eight
// digest words H0..H7 one per cycle on the out_ channel while out_ready is
// high, word 7 flagged by out_last_word, and restarts at the initial hash value.
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  sha256_pkg::item_t in_item, q_item;
  logic              q_valid, q_ready;

  assign in_item.action    = in_action;
  assign in_item.data_byte = in_data_byte;

  sha256_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_item(in_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
  );

  sha256_engine u_engine (
    .clk(clk), .rst_n(rst_n),
    .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );

  a_idx_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7))) else $error("last flag");
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word) |=> out_valid) else $error("digest gap");
  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_digest_word)) else $error("word changed");
endmodule

[tb/sv/sha256_checker.sv]
// Checker for the SHA-256 message hasher: predicts digests and compares outputs.
module sha256_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          fail_count,
  output int          words_pending,
  output int          digests_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic [31:0]  chain [8];
  logic [7:0]   block_buf [64];
  logic [5:0]   fill;
  logic [60:0]  byte_total;
  digest_word_t digest_q [$];

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
           + w[t-7] + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
    v = chain;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::round_k(t[5:0]) + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endtask

  task automatic restart();
    for (int i = 0; i < 8; i++) chain[i] = sha256_pkg::iv_word(i[2:0]);
    fill = '0;
    byte_total = '0;
  endtask

  // Padding: 0x80, zeros, then 64-bit big-endian bit count.
  task automatic finish_message();
    logic [63:0] bits;
    int          pos;
    digest_word_t d;
    bits = {byte_total, 3'b000};
    pos = fill;
    block_buf[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin block_buf[pos] = 8'h00; pos++; end
      compress();
      pos = 0;
    end
    while (pos < 56) begin block_buf[pos] = 8'h00; pos++; end
    for (int i = 0; i < 8; i++) block_buf[56+i] = bits[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      d.word = chain[i];
      d.index = i[2:0];
      d.last = (i == 7);
      digest_q.push_back(d);
    end
    restart();
  endtask

  assign words_pending = digest_q.size();

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (!rst_n) begin
      restart();
      digest_q.delete();
      fail_count <= 0;
      digests_seen <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_action == sha256_pkg::ACT_ABSORB) begin
          block_buf[fill] = in_data_byte;
          fill = fill + 6'd1;
          byte_total = byte_total + 61'd1;
          if (fill == 6'd0) compress();
        end else begin
          finish_message();
        end
      end
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h idx %0d last %0b", $time,
                   out_digest_word, out_word_index, out_last_word);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = digest_q.pop_front();
          if (exp_w.word !== out_digest_word || exp_w.index !== out_word_index ||
              exp_w.last !== out_last_word) begin
            $display("%0t: digest mismatch exp %h/%0d/%0b got %h/%0d/%0b", $time,
                     exp_w.word, exp_w.index, exp_w.last,
                     out_digest_word, out_word_index, out_last_word);
            fail_count <= fail_count + 1;
          end
          if (out_last_word) digests_seen <= digests_seen + 1;
        end
      end
    end
  end
endmodule

[tb/sv/testbench.sv]
// Top of the SHA-256 hasher testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = sha256_pkg::ACT_ABSORB;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  int          fail_count;
  int          words_pending;
  int          digests_seen;

  // Idle/stall percentages per phase; hold_off forces a long receiver stall.
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_off = 1'b0;
  int          hold_cycles = 0;
  int          items_sent = 0;
  longint      cycle_count = 0;

  localparam longint CYCLE_LIMIT = 400000;

  sha256_message_hasher DUT (.*);

  sha256_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a counted hold-off stretch.
  always @(negedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One transaction: idle gaps at random, then hold valid until accepted.
  // Driven at the falling edge; back-to-back items just keep valid high.
  task automatic send_item(input logic act, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    in_action = act;
    in_data_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    items_sent++;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_item(sha256_pkg::ACT_ABSORB, 8'($urandom));
    send_item(sha256_pkg::ACT_FINISH, 8'($urandom));
  endtask

  task automatic drain();
    while (words_pending != 0) @(negedge clk);
  endtask

  // Mostly short messages; some land around the padding spill point.
  function automatic int pick_length();
    int sel;
    sel = $urandom_range(9);
    if (sel < 8) return $urandom_range(8);
    return 52 + $urandom_range(12);
  endfunction

  initial begin
    int phase_items;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty message, "abc", edge byte values, finish data ignored.
    send_item(sha256_pkg::ACT_FINISH, 8'hff);
    send_item(sha256_pkg::ACT_ABSORB, 8'h61);
    send_item(sha256_pkg::ACT_ABSORB, 8'h62);
    send_item(sha256_pkg::ACT_ABSORB, 8'h63);
    send_item(sha256_pkg::ACT_FINISH, 8'h00);
    send_item(sha256_pkg::ACT_ABSORB, 8'h00);
    send_item(sha256_pkg::ACT_ABSORB, 8'hff);
    send_item(sha256_pkg::ACT_ABSORB, 8'h55);
    send_item(sha256_pkg::ACT_ABSORB, 8'haa);
    send_item(sha256_pkg::ACT_FINISH, 8'h5a);
    drain();

    // Padding boundaries: 56 spills into a second block, 64 fills one exactly.
    send_message(56);
    send_message(64);

    // Long receiver hold-off while sender keeps offering: input must back up.
    hold_off = 1'b1;
    fork
      begin
        send_message(3);
        send_message(0);
        send_message(2);
      end
      begin
        while (hold_cycles < 300) @(negedge clk);
        hold_off = 1'b0;
      end
    join
    drain();

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 60 : (ph == 3) ? 11 : 0;
      recv_stall_pct = (ph == 2) ? 60 : (ph == 3) ? 11 : 0;
      phase_items = items_sent;
      while (items_sent - phase_items < 18) send_message(pick_length());
      // Sender pause until every outstanding word is back.
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    drain();
    repeat (300) @(negedge clk);
    $display("Covered %0d transactions, %0d digests checked, incl. empty and",
             items_sent, digests_seen);
    $display("padding-boundary messages, multi-block input and a long output hold-off.");
    if (fail_count == 0 && words_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[sha256_message_hasher.f]
hdl/sha256_pkg.sv
hdl/sha256_queue.sv
hdl/sha256_engine.sv
hdl/sha256_message_hasher.sv
tb/sv/sha256_checker.sv
tb/sv/testbench.sv
